@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker module of the polygon area block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define PAH_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define PAH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/pah_pkg.sv @@
// Shared widths and pipeline control types of the polygon area block.
package pah_pkg;

    localparam int IN_W  = 16;
    localparam int ACC_W = 48;
    localparam int OUT_W = 47;

    // Control bits that travel with a vertex through the pipeline.
    typedef struct packed {
        logic edge_ok;   // the edge from the previous vertex exists
        logic closing;   // last vertex of a contour: closing edge exists
        logic last;      // last vertex of a region: a result is due
        logic outer;     // the vertex belongs to the outer contour
    } pah_ctrl_t;

endpackage

@@ rtl/core/pah_ifs.sv @@
// Valid/ready channel interfaces for vertices and region results.
interface pah_vtx_if import pah_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic                   contour_end;
    logic                   region_end;

    modport source (output valid, x, y, contour_end, region_end, input ready);
    modport sink (input valid, x, y, contour_end, region_end, output ready);
endinterface

interface pah_res_if import pah_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] net_area;
    logic [OUT_W-1:0]        outer_area;
    logic [OUT_W-1:0]        hole_area;
    logic [OUT_W-1:0]        outer_perimeter;

    modport source (output valid, net_area, outer_area, hole_area, outer_perimeter,
                    input ready);
    modport sink (input valid, net_area, outer_area, hole_area, outer_perimeter,
                  output ready);
endinterface

@@ rtl/core/pah_front.sv @@
// Vertex intake: contour tracking and the input register that holds both edges.
module pah_front import pah_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    pah_vtx_if.sink                      vertex,
    output logic                         seg_valid,
    input  logic                         seg_ready,
    output logic signed [COORD_BITS-1:0] seg_ax,
    output logic signed [COORD_BITS-1:0] seg_ay,
    output logic signed [COORD_BITS-1:0] seg_bx,
    output logic signed [COORD_BITS-1:0] seg_by,
    output logic signed [COORD_BITS-1:0] seg_fx,
    output logic signed [COORD_BITS-1:0] seg_fy,
    output pah_ctrl_t                    seg_ctrl
);

    localparam int EXT_W = (COORD_BITS > IN_W) ? COORD_BITS : IN_W;

    logic [EXT_W-1:0]              x_ext;
    logic [EXT_W-1:0]              y_ext;
    logic signed [COORD_BITS-1:0]  x_c;
    logic signed [COORD_BITS-1:0]  y_c;
    logic                          accept;
    logic                          closing;

    logic signed [COORD_BITS-1:0]  prev_x_reg;
    logic signed [COORD_BITS-1:0]  prev_y_reg;
    logic signed [COORD_BITS-1:0]  first_x_reg;
    logic signed [COORD_BITS-1:0]  first_y_reg;
    logic                          start_reg;
    logic                          outer_reg;
    logic                          seg_valid_reg;
    logic signed [COORD_BITS-1:0]  ax_reg;
    logic signed [COORD_BITS-1:0]  ay_reg;
    logic signed [COORD_BITS-1:0]  bx_reg;
    logic signed [COORD_BITS-1:0]  by_reg;
    logic signed [COORD_BITS-1:0]  fx_reg;
    logic signed [COORD_BITS-1:0]  fy_reg;
    pah_ctrl_t                     ctrl_reg;

    // Only the low COORD_BITS bits of a coordinate count; above 16 bits the
    // field is taken as it stands, with zeros above it.
    assign x_ext = EXT_W'($unsigned(vertex.x));
    assign y_ext = EXT_W'($unsigned(vertex.y));
    assign x_c   = x_ext[COORD_BITS-1:0];
    assign y_c   = y_ext[COORD_BITS-1:0];

    assign closing      = vertex.contour_end | vertex.region_end;
    assign vertex.ready = !seg_valid_reg || seg_ready;
    assign accept       = vertex.valid && vertex.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            first_x_reg   <= '0;
            first_y_reg   <= '0;
            start_reg     <= 1'b1;
            outer_reg     <= 1'b1;
            seg_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                prev_x_reg    <= x_c;
                prev_y_reg    <= y_c;
                if (start_reg)
                begin
                    first_x_reg <= x_c;
                    first_y_reg <= y_c;
                end
                start_reg     <= closing;
                if (vertex.region_end)
                begin
                    outer_reg <= 1'b1;
                end
                else if (closing)
                begin
                    outer_reg <= 1'b0;
                end
                seg_valid_reg <= 1'b1;
            end
            else if (seg_ready)
            begin
                seg_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ax_reg           <= prev_x_reg;
            ay_reg           <= prev_y_reg;
            bx_reg           <= x_c;
            by_reg           <= y_c;
            fx_reg           <= start_reg ? x_c : first_x_reg;
            fy_reg           <= start_reg ? y_c : first_y_reg;
            ctrl_reg.edge_ok <= !start_reg;
            ctrl_reg.closing <= closing;
            ctrl_reg.last    <= vertex.region_end;
            ctrl_reg.outer   <= outer_reg;
        end
    end

    assign seg_valid = seg_valid_reg;
    assign seg_ax    = ax_reg;
    assign seg_ay    = ay_reg;
    assign seg_bx    = bx_reg;
    assign seg_by    = by_reg;
    assign seg_fx    = fx_reg;
    assign seg_fy    = fy_reg;
    assign seg_ctrl  = ctrl_reg;

endmodule

@@ rtl/core/pah_edge.sv @@
// Edge terms: shoelace products and axis-aligned edge lengths, then their sums.
module pah_edge import pah_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         seg_valid,
    output logic                         seg_ready,
    input  logic signed [COORD_BITS-1:0] seg_ax,
    input  logic signed [COORD_BITS-1:0] seg_ay,
    input  logic signed [COORD_BITS-1:0] seg_bx,
    input  logic signed [COORD_BITS-1:0] seg_by,
    input  logic signed [COORD_BITS-1:0] seg_fx,
    input  logic signed [COORD_BITS-1:0] seg_fy,
    input  pah_ctrl_t                    seg_ctrl,
    output logic                         term_valid,
    input  logic                         term_ready,
    output logic [ACC_W-1:0]             term_cross,
    output logic [COORD_BITS:0]          term_perim,
    output pah_ctrl_t                    term_ctrl
);

    localparam int PROD_W = 2 * COORD_BITS;

    // Absolute difference of two coordinates; it always fits COORD_BITS bits.
    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [COORD_BITS:0] d;
        logic [COORD_BITS:0]        m;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        m = d[COORD_BITS] ? (COORD_BITS+1)'(-d) : d;
        return m[COORD_BITS-1:0];
    endfunction

    // Length of an edge that runs along an axis; a diagonal edge counts zero.
    function automatic logic [COORD_BITS-1:0] axis_len(
        input logic signed [COORD_BITS-1:0] x0,
        input logic signed [COORD_BITS-1:0] y0,
        input logic signed [COORD_BITS-1:0] x1,
        input logic signed [COORD_BITS-1:0] y1
    );
        logic [COORD_BITS-1:0] len;
        if (x0 == x1)
        begin
            len = abs_diff(y0, y1);
        end
        else if (y0 == y1)
        begin
            len = abs_diff(x0, x1);
        end
        else
        begin
            len = '0;
        end
        return len;
    endfunction

    logic                         prod_valid_reg;
    logic signed [PROD_W-1:0]     p1_reg;
    logic signed [PROD_W-1:0]     p2_reg;
    logic signed [PROD_W-1:0]     p3_reg;
    logic signed [PROD_W-1:0]     p4_reg;
    logic [COORD_BITS-1:0]        per1_reg;
    logic [COORD_BITS-1:0]        per2_reg;
    pah_ctrl_t                    ctrl2_reg;

    logic                         term_valid_reg;
    logic [ACC_W-1:0]             cross_reg;
    logic [COORD_BITS:0]          perim_reg;
    pah_ctrl_t                    ctrl3_reg;

    logic                         s3_load_ok;
    logic                         prod_fire;
    logic                         seg_fire;
    logic [ACC_W-1:0]             c_open;
    logic [ACC_W-1:0]             c_close;

    assign s3_load_ok = !term_valid_reg || term_ready;
    assign prod_fire  = prod_valid_reg && s3_load_ok;
    assign seg_ready  = !prod_valid_reg || s3_load_ok;
    assign seg_fire   = seg_valid && seg_ready;

    // Cross terms of the edge from the previous vertex and of the closing edge.
    always_comb
    begin
        c_open  = ctrl2_reg.edge_ok ? (ACC_W'(p1_reg) - ACC_W'(p2_reg)) : '0;
        c_close = ctrl2_reg.closing ? (ACC_W'(p3_reg) - ACC_W'(p4_reg)) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            term_valid_reg <= 1'b0;
        end
        else
        begin
            if (seg_fire)
            begin
                prod_valid_reg <= 1'b1;
            end
            else if (s3_load_ok)
            begin
                prod_valid_reg <= 1'b0;
            end

            if (prod_fire)
            begin
                term_valid_reg <= 1'b1;
            end
            else if (term_ready)
            begin
                term_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (seg_fire)
        begin
            p1_reg    <= seg_ax * seg_by;
            p2_reg    <= seg_ay * seg_bx;
            p3_reg    <= seg_bx * seg_fy;
            p4_reg    <= seg_by * seg_fx;
            per1_reg  <= (seg_ctrl.outer && seg_ctrl.edge_ok) ?
                         axis_len(seg_ax, seg_ay, seg_bx, seg_by) : '0;
            per2_reg  <= (seg_ctrl.outer && seg_ctrl.closing) ?
                         axis_len(seg_bx, seg_by, seg_fx, seg_fy) : '0;
            ctrl2_reg <= seg_ctrl;
        end
        if (prod_fire)
        begin
            cross_reg <= c_open + c_close;
            perim_reg <= {1'b0, per1_reg} + {1'b0, per2_reg};
            ctrl3_reg <= ctrl2_reg;
        end
    end

    assign term_valid = term_valid_reg;
    assign term_cross = cross_reg;
    assign term_perim = perim_reg;
    assign term_ctrl  = ctrl3_reg;

endmodule

@@ rtl/core/pah_accum.sv @@
// Contour and region accumulation, area magnitude and the result register.
module pah_accum import pah_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                term_valid,
    output logic                term_ready,
    input  logic [ACC_W-1:0]    term_cross,
    input  logic [COORD_BITS:0] term_perim,
    input  pah_ctrl_t           term_ctrl,
    pah_res_if.source           result
);

    logic [ACC_W-1:0]        cross_sum_reg;
    logic [ACC_W-1:0]        perim_acc_reg;
    logic [ACC_W-1:0]        outer_acc_reg;
    logic [ACC_W-1:0]        hole_acc_reg;
    logic [ACC_W-1:0]        net_acc_reg;

    logic                    sum_valid_reg;
    logic [ACC_W-1:0]        total_reg;
    logic [ACC_W-1:0]        perim4_reg;
    logic                    last4_reg;
    logic                    outer4_reg;

    logic                    area_valid_reg;
    logic [OUT_W-1:0]        area_reg;
    logic [ACC_W-1:0]        perim5_reg;
    logic                    last5_reg;
    logic                    outer5_reg;

    logic                    res_valid_reg;
    logic signed [ACC_W-1:0] net_out_reg;
    logic [OUT_W-1:0]        outer_out_reg;
    logic [OUT_W-1:0]        hole_out_reg;
    logic [OUT_W-1:0]        perim_out_reg;

    logic                    term_fire;
    logic                    s5_load_ok;
    logic                    sum_fire;
    logic                    area_take;
    logic [ACC_W-1:0]        total_next;
    logic [ACC_W-1:0]        perim_next;
    logic [ACC_W-1:0]        mag;
    logic [ACC_W-1:0]        area_ext;
    logic [ACC_W-1:0]        outer_next;
    logic [ACC_W-1:0]        hole_next;
    logic [ACC_W-1:0]        net_next;

    // A region's closing item waits here while the previous result is unread.
    assign area_take  = area_valid_reg && (!last5_reg || !res_valid_reg || result.ready);
    assign s5_load_ok = !area_valid_reg || area_take;
    assign sum_fire   = sum_valid_reg && s5_load_ok;
    assign term_ready = !sum_valid_reg || s5_load_ok;
    assign term_fire  = term_valid && term_ready;

    assign total_next = cross_sum_reg + term_cross;
    assign perim_next = perim_acc_reg + ACC_W'(term_perim);

    // Two's complement magnitude; the most negative sum maps onto 2^47.
    assign mag      = total_reg[ACC_W-1] ? (~total_reg + ACC_W'(1)) : total_reg;
    assign area_ext = ACC_W'(area_reg);

    always_comb
    begin
        if (outer5_reg)
        begin
            outer_next = area_ext;
            hole_next  = hole_acc_reg;
            net_next   = area_ext - hole_acc_reg;
        end
        else
        begin
            outer_next = outer_acc_reg;
            hole_next  = hole_acc_reg + area_ext;
            net_next   = net_acc_reg - area_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cross_sum_reg  <= '0;
            perim_acc_reg  <= '0;
            outer_acc_reg  <= '0;
            hole_acc_reg   <= '0;
            net_acc_reg    <= '0;
            sum_valid_reg  <= 1'b0;
            area_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (term_fire)
            begin
                cross_sum_reg <= term_ctrl.closing ? '0 : total_next;
                perim_acc_reg <= term_ctrl.last ? '0 : perim_next;
                // Only contour ends carry anything further down.
                sum_valid_reg <= term_ctrl.closing;
            end
            else if (s5_load_ok)
            begin
                sum_valid_reg <= 1'b0;
            end

            if (sum_fire)
            begin
                area_valid_reg <= 1'b1;
            end
            else if (area_take)
            begin
                area_valid_reg <= 1'b0;
            end

            if (area_take)
            begin
                if (last5_reg)
                begin
                    outer_acc_reg <= '0;
                    hole_acc_reg  <= '0;
                    net_acc_reg   <= '0;
                end
                else
                begin
                    outer_acc_reg <= outer_next;
                    hole_acc_reg  <= hole_next;
                    net_acc_reg   <= net_next;
                end
            end

            if (area_take && last5_reg)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (term_fire)
        begin
            total_reg  <= total_next;
            perim4_reg <= perim_next;
            last4_reg  <= term_ctrl.last;
            outer4_reg <= term_ctrl.outer;
        end
        if (sum_fire)
        begin
            area_reg   <= mag[ACC_W-1:1];
            perim5_reg <= perim4_reg;
            last5_reg  <= last4_reg;
            outer5_reg <= outer4_reg;
        end
        if (area_take && last5_reg)
        begin
            net_out_reg   <= net_next;
            outer_out_reg <= outer_next[OUT_W-1:0];
            hole_out_reg  <= hole_next[OUT_W-1:0];
            perim_out_reg <= perim5_reg[OUT_W-1:0];
        end
    end

    assign result.valid           = res_valid_reg;
    assign result.net_area        = net_out_reg;
    assign result.outer_area      = outer_out_reg;
    assign result.hole_area       = hole_out_reg;
    assign result.outer_perimeter = perim_out_reg;

endmodule

@@ rtl/core/polygon_area_with_holes.sv @@
// Top level of the polygon area block: net area with holes and outer perimeter.
//
// Vertices stream in one per transfer; contour_end closes a contour and
// region_end closes the region and produces one result. The first contour of
// a region is its outer boundary, every later one a hole. The block takes one
// vertex every cycle as long as results are taken when offered. The path is
// a six-stage pipeline: input register, four shoelace multipliers, edge sums,
// contour accumulator, magnitude, and the result register. The result register
// holds a result until it is taken while later vertices keep moving behind it.
// When the next region's closing contour reaches the magnitude stage while a
// result still waits, the stall backs up to the input. All accumulators wrap
// at 48 bits.
module polygon_area_with_holes import pah_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    pah_vtx_if.sink    vertex,
    pah_res_if.source  result
);

    logic                         seg_valid;
    logic                         seg_ready;
    logic signed [COORD_BITS-1:0] seg_ax;
    logic signed [COORD_BITS-1:0] seg_ay;
    logic signed [COORD_BITS-1:0] seg_bx;
    logic signed [COORD_BITS-1:0] seg_by;
    logic signed [COORD_BITS-1:0] seg_fx;
    logic signed [COORD_BITS-1:0] seg_fy;
    pah_ctrl_t                    seg_ctrl;

    logic                         term_valid;
    logic                         term_ready;
    logic [ACC_W-1:0]             term_cross;
    logic [COORD_BITS:0]          term_perim;
    pah_ctrl_t                    term_ctrl;

    pah_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .vertex    (vertex),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg_ax    (seg_ax),
        .seg_ay    (seg_ay),
        .seg_bx    (seg_bx),
        .seg_by    (seg_by),
        .seg_fx    (seg_fx),
        .seg_fy    (seg_fy),
        .seg_ctrl  (seg_ctrl)
    );

    pah_edge #(
        .COORD_BITS (COORD_BITS)
    ) u_edge (
        .clk        (clk),
        .rst_n      (rst_n),
        .seg_valid  (seg_valid),
        .seg_ready  (seg_ready),
        .seg_ax     (seg_ax),
        .seg_ay     (seg_ay),
        .seg_bx     (seg_bx),
        .seg_by     (seg_by),
        .seg_fx     (seg_fx),
        .seg_fy     (seg_fy),
        .seg_ctrl   (seg_ctrl),
        .term_valid (term_valid),
        .term_ready (term_ready),
        .term_cross (term_cross),
        .term_perim (term_perim),
        .term_ctrl  (term_ctrl)
    );

    pah_accum #(
        .COORD_BITS (COORD_BITS)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .term_valid (term_valid),
        .term_ready (term_ready),
        .term_cross (term_cross),
        .term_perim (term_perim),
        .term_ctrl  (term_ctrl),
        .result     (result)
    );

endmodule

@@ rtl/core/pah_checker.sv @@
// Port-level checks on the result channel of the polygon area block.
`include "assert_macros.svh"

module pah_checker import pah_pkg::*; (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    res_valid,
    input logic                    res_ready,
    input logic signed [ACC_W-1:0] net_area,
    input logic [OUT_W-1:0]        outer_area,
    input logic [OUT_W-1:0]        hole_area,
    input logic [OUT_W-1:0]        outer_perimeter
);

    logic [ACC_W+3*OUT_W-1:0] res_bits;
    logic [OUT_W-1:0]         net_low;
    logic                     outer_ok;

    assign res_bits = {net_area, outer_area, hole_area, outer_perimeter};
    assign net_low  = OUT_W'(outer_area - hole_area);
    assign outer_ok = !outer_area[OUT_W-1] || (outer_area[OUT_W-2:0] == '0);

    // A result offered and not taken stays offered, with the same contents.
    `PAH_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped")
    `PAH_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(res_bits), "result changed")

    // The net area is the outer area minus the hole sum, modulo 2^47.
    `PAH_ASSERT_IMP(a_net_match, res_valid, net_area[OUT_W-1:0] == net_low, "net area off")

    // Half the magnitude of a 48-bit sum never exceeds 2^46.
    `PAH_ASSERT_IMP(a_outer_range, res_valid, outer_ok, "outer area too large")

endmodule

bind polygon_area_with_holes pah_checker u_pah_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .net_area        (result.net_area),
    .outer_area      (result.outer_area),
    .hole_area       (result.hole_area),
    .outer_perimeter (result.outer_perimeter)
);
